// ===== rtl/core/lavm_pkg.sv =====
`default_nettype none
package lavm_pkg;

   localparam int NORM_LATENCY = 55;
   localparam int SQRT_STEPS   = 32;
   localparam int DIV_STEPS    = 17;

   localparam logic signed [17:0] Q_ONE  = 18'sd65536;
   localparam logic signed [17:0] Q_MONE = -18'sd65536;
   localparam logic signed [36:0] T_MAX  = 37'sd2147483647;
   localparam logic signed [36:0] T_MIN  = -37'sd2147483648;

   localparam logic [1:0] REG_UP_X = 2'd0;
   localparam logic [1:0] REG_UP_Y = 2'd1;
   localparam logic [1:0] REG_UP_Z = 2'd2;

   typedef struct packed {
      logic [2:0][30:0] mag;
      logic [2:0]       neg;
      logic             zero;
   } side_type;

   typedef struct packed {
      logic             ok;
      logic [2:0][17:0] lu;
      logic [2:0][31:0] eye;
   } carry_type;

   function automatic logic signed [35:0] round_q16(input logic signed [50:0] v);
      logic [50:0] mag;
      logic [50:0] rnd;
      logic [35:0] m;
      mag = v[50] ? 51'(-v) : 51'(v);
      rnd = (mag + 51'h8000) >> 16;
      m   = rnd[35:0];
      return v[50] ? -$signed(m) : $signed(m);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lavm_normalize.sv =====
`default_nettype none
module lavm_normalize import lavm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic signed [63:0] in_vec [3],
   output logic               out_valid,
   output logic               out_zero,
   output logic signed [31:0] out_scaled [3],
   output logic signed [17:0] out_unit [3]
);

   logic [NORM_LATENCY-1:0] vld_ff;

   logic [63:0] a_mag_in [3];
   logic [2:0]  a_neg_in;
   logic [63:0] a_max_in;
   logic [63:0] a_mag_ff [3];
   logic [2:0]  a_neg_ff;
   logic [63:0] a_max_ff;

   logic [5:0]  b_pos_in;
   logic [5:0]  b_pos_ff;
   logic        b_zero_ff;
   logic [63:0] b_mag_ff [3];
   logic [2:0]  b_neg_ff;

   side_type    c_side_in;
   side_type    c_side_ff;
   logic [61:0] d_sq_ff [3];
   side_type    d_side_ff;
   logic [63:0] e_sum_ff;
   side_type    e_side_ff;

   logic [63:0] sq_rem_src [SQRT_STEPS];
   logic [63:0] sq_res_src [SQRT_STEPS];
   side_type    sq_side_src [SQRT_STEPS];
   logic [63:0] sq_rem_in [SQRT_STEPS];
   logic [63:0] sq_res_in [SQRT_STEPS];
   logic [63:0] sq_rem_ff [SQRT_STEPS];
   logic [63:0] sq_res_ff [SQRT_STEPS];
   side_type    sq_side_ff [SQRT_STEPS];

   logic [48:0] dv_rem_src [DIV_STEPS][3];
   logic [16:0] dv_q_src [DIV_STEPS][3];
   logic [31:0] dv_len_src [DIV_STEPS];
   side_type    dv_side_src [DIV_STEPS];
   logic [48:0] dv_rem_in [DIV_STEPS][3];
   logic [16:0] dv_q_in [DIV_STEPS][3];
   logic [48:0] dv_rem_ff [DIV_STEPS][3];
   logic [16:0] dv_q_ff [DIV_STEPS][3];
   logic [31:0] dv_len_ff [DIV_STEPS];
   side_type    dv_side_ff [DIV_STEPS];

   logic               o_zero_ff;
   logic signed [31:0] o_scaled_ff [3];
   logic signed [17:0] o_unit_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[NORM_LATENCY-2:0], in_valid};
      end
   end

   always_comb begin
      a_max_in = '0;
      for (int i = 0; i < 3; i++) begin
         a_neg_in[i] = in_vec[i][63];
         a_mag_in[i] = in_vec[i][63] ? 64'(-in_vec[i]) : 64'(in_vec[i]);
         if (a_mag_in[i] > a_max_in) begin
            a_max_in = a_mag_in[i];
         end
      end
   end

   always_comb begin
      b_pos_in = '0;
      for (int i = 0; i < 64; i++) begin
         if (a_max_ff[i]) begin
            b_pos_in = 6'(i);
         end
      end
   end

   always_comb begin
      logic [63:0] sh;
      c_side_in.neg  = b_neg_ff;
      c_side_in.zero = b_zero_ff;
      for (int i = 0; i < 3; i++) begin
         if (b_pos_ff >= 6'd30) begin
            sh = b_mag_ff[i] >> (b_pos_ff - 6'd30);
         end else begin
            sh = b_mag_ff[i] << (6'd30 - b_pos_ff);
         end
         c_side_in.mag[i] = sh[30:0];
      end
   end

   always_comb begin
      logic [63:0] bitv;
      for (int s = 0; s < SQRT_STEPS; s++) begin
         if (s == 0) begin
            sq_rem_src[s]  = e_sum_ff;
            sq_res_src[s]  = '0;
            sq_side_src[s] = e_side_ff;
         end else begin
            sq_rem_src[s]  = sq_rem_ff[s-1];
            sq_res_src[s]  = sq_res_ff[s-1];
            sq_side_src[s] = sq_side_ff[s-1];
         end
      end
      for (int s = 0; s < SQRT_STEPS; s++) begin
         bitv = 64'd1 << (62 - 2 * s);
         if (sq_rem_src[s] >= sq_res_src[s] + bitv) begin
            sq_rem_in[s] = sq_rem_src[s] - (sq_res_src[s] + bitv);
            sq_res_in[s] = (sq_res_src[s] >> 1) + bitv;
         end else begin
            sq_rem_in[s] = sq_rem_src[s];
            sq_res_in[s] = sq_res_src[s] >> 1;
         end
      end
   end

   always_comb begin
      logic [48:0] dvs;
      for (int d = 0; d < DIV_STEPS; d++) begin
         for (int i = 0; i < 3; i++) begin
            if (d == 0) begin
               dv_rem_src[d][i] = {2'b00, sq_side_ff[SQRT_STEPS-1].mag[i], 16'h0000}
                                + 49'(sq_res_ff[SQRT_STEPS-1][31:1]);
               dv_q_src[d][i]   = '0;
            end else begin
               dv_rem_src[d][i] = dv_rem_ff[d-1][i];
               dv_q_src[d][i]   = dv_q_ff[d-1][i];
            end
         end
         if (d == 0) begin
            dv_len_src[d]  = sq_res_ff[SQRT_STEPS-1][31:0];
            dv_side_src[d] = sq_side_ff[SQRT_STEPS-1];
         end else begin
            dv_len_src[d]  = dv_len_ff[d-1];
            dv_side_src[d] = dv_side_ff[d-1];
         end
      end
      for (int d = 0; d < DIV_STEPS; d++) begin
         dvs = 49'(dv_len_src[d]) << (DIV_STEPS - 1 - d);
         for (int i = 0; i < 3; i++) begin
            dv_q_in[d][i] = dv_q_src[d][i];
            if (dv_rem_src[d][i] >= dvs) begin
               dv_rem_in[d][i] = dv_rem_src[d][i] - dvs;
               dv_q_in[d][i][DIV_STEPS-1-d] = 1'b1;
            end else begin
               dv_rem_in[d][i] = dv_rem_src[d][i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_mag_ff  <= a_mag_in;
         a_neg_ff  <= a_neg_in;
         a_max_ff  <= a_max_in;
         b_pos_ff  <= b_pos_in;
         b_zero_ff <= (a_max_ff == '0);
         b_mag_ff  <= a_mag_ff;
         b_neg_ff  <= a_neg_ff;
         c_side_ff <= c_side_in;
         for (int i = 0; i < 3; i++) begin
            d_sq_ff[i] <= 62'(c_side_ff.mag[i]) * 62'(c_side_ff.mag[i]);
         end
         d_side_ff <= c_side_ff;
         e_sum_ff  <= 64'(d_sq_ff[0]) + 64'(d_sq_ff[1]) + 64'(d_sq_ff[2]);
         e_side_ff <= d_side_ff;
         sq_rem_ff  <= sq_rem_in;
         sq_res_ff  <= sq_res_in;
         sq_side_ff <= sq_side_src;
         dv_rem_ff  <= dv_rem_in;
         dv_q_ff    <= dv_q_in;
         dv_len_ff  <= dv_len_src;
         dv_side_ff <= dv_side_src;
         o_zero_ff  <= dv_side_ff[DIV_STEPS-1].zero;
         for (int i = 0; i < 3; i++) begin
            if (dv_side_ff[DIV_STEPS-1].neg[i]) begin
               o_scaled_ff[i] <= -$signed({1'b0, dv_side_ff[DIV_STEPS-1].mag[i]});
               o_unit_ff[i]   <= -$signed({1'b0, dv_q_ff[DIV_STEPS-1][i]});
            end else begin
               o_scaled_ff[i] <= $signed({1'b0, dv_side_ff[DIV_STEPS-1].mag[i]});
               o_unit_ff[i]   <= $signed({1'b0, dv_q_ff[DIV_STEPS-1][i]});
            end
         end
      end
   end

   assign out_valid  = vld_ff[NORM_LATENCY-1];
   assign out_zero   = o_zero_ff;
   assign out_scaled = o_scaled_ff;
   assign out_unit   = o_unit_ff;

endmodule
`default_nettype wire

// ===== rtl/core/look_at_view_matrix_core.sv =====
`default_nettype none
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | eye_x..z, aim_x..z (signed Q16.16)
// rsp     | out       | rsp_valid/rsp_ready  | m00..m22 (18b), t0..t2 (32b)
// csr     | in        | psel/penable/pwrite  | up_x, up_y, up_z at 0x0, 0x4, 0x8
// The pipeline has 117 register stages; one transaction enters per cycle, except
// while rsp_ready is low with a result waiting, which stalls it.
// The look and right normalize units in series (isqrt and divide steps, 55 stages
// each) set the depth.
// Synchronous reset clears valid bits and loads the up vector (0, 1.0, 0).
// rsp_ready low with a result waiting freezes every stage; nothing is lost.
module look_at_view_matrix_core import lavm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_eye_x,
   input  logic signed [31:0] req_eye_y,
   input  logic signed [31:0] req_eye_z,
   input  logic signed [31:0] req_aim_x,
   input  logic signed [31:0] req_aim_y,
   input  logic signed [31:0] req_aim_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [17:0] rsp_m00,
   output logic signed [17:0] rsp_m01,
   output logic signed [17:0] rsp_m02,
   output logic signed [17:0] rsp_m10,
   output logic signed [17:0] rsp_m11,
   output logic signed [17:0] rsp_m12,
   output logic signed [17:0] rsp_m20,
   output logic signed [17:0] rsp_m21,
   output logic signed [17:0] rsp_m22,
   output logic signed [31:0] rsp_t0,
   output logic signed [31:0] rsp_t1,
   output logic signed [31:0] rsp_t2,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic               adv;
   logic signed [31:0] up_ff [3];

   logic               f_valid_ff;
   logic signed [31:0] f_eye_ff [3];
   logic signed [63:0] f_look_ff [3];
   logic signed [63:0] f_up_ff [3];

   logic               n1_valid, n1_zero, n2_valid, n2_zero;
   logic signed [31:0] n1_scaled [3], n2_scaled [3];
   logic signed [17:0] n1_unit [3], n2_unit [3];
   logic [2:0][31:0]   eye_dly_ff [NORM_LATENCY];

   logic               x1_valid_ff;
   logic signed [63:0] x1_prod_ff [6];
   carry_type          x1_carry_ff;
   logic               x2_valid_ff;
   logic signed [63:0] x2_cr_ff [3];
   carry_type          x2_carry_ff;

   logic               n3_valid, n3_zero;
   logic signed [31:0] n3_scaled [3];
   logic signed [17:0] n3_unit [3];
   carry_type          carry_dly_ff [NORM_LATENCY];

   logic               p1_valid_ff;
   logic signed [35:0] p1_prod_ff [6];
   logic signed [17:0] p1_ru_ff [3];
   carry_type          p1_carry_ff;

   logic signed [17:0] p2_rows_in [3][3];
   logic               p2_valid_ff;
   logic signed [17:0] p2_rows_ff [3][3];
   logic [2:0][31:0]   p2_eye_ff;

   logic               t1_valid_ff;
   logic signed [49:0] t1_prod_ff [3][3];
   logic signed [17:0] t1_rows_ff [3][3];

   logic signed [31:0] t_in [3];
   logic               rsp_valid_ff;
   logic signed [17:0] rsp_rows_ff [3][3];
   logic signed [31:0] rsp_t_ff [3];

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff[0] <= 32'sd0;
         up_ff[1] <= 32'sd65536;
         up_ff[2] <= 32'sd0;
      end else if (psel && penable && pwrite) begin
         case (paddr[3:2])
            REG_UP_X: up_ff[0] <= pwdata;
            REG_UP_Y: up_ff[1] <= pwdata;
            REG_UP_Z: up_ff[2] <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_UP_X: prdata = up_ff[0];
         REG_UP_Y: prdata = up_ff[1];
         REG_UP_Z: prdata = up_ff[2];
         default:  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff   <= 1'b0;
         x1_valid_ff  <= 1'b0;
         x2_valid_ff  <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         t1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         f_valid_ff   <= req_valid;
         x1_valid_ff  <= n1_valid;
         x2_valid_ff  <= x1_valid_ff;
         p1_valid_ff  <= n3_valid;
         p2_valid_ff  <= p1_valid_ff;
         t1_valid_ff  <= p2_valid_ff;
         rsp_valid_ff <= t1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_eye_ff[0]  <= req_eye_x;
         f_eye_ff[1]  <= req_eye_y;
         f_eye_ff[2]  <= req_eye_z;
         f_look_ff[0] <= 64'(req_aim_x) - 64'(req_eye_x);
         f_look_ff[1] <= 64'(req_aim_y) - 64'(req_eye_y);
         f_look_ff[2] <= 64'(req_aim_z) - 64'(req_eye_z);
         for (int i = 0; i < 3; i++) begin
            f_up_ff[i] <= 64'(up_ff[i]);
         end
      end
   end

   lavm_normalize u_norm_look (
      .clock      (clock),
      .reset      (reset),
      .advance    (adv),
      .in_valid   (f_valid_ff),
      .in_vec     (f_look_ff),
      .out_valid  (n1_valid),
      .out_zero   (n1_zero),
      .out_scaled (n1_scaled),
      .out_unit   (n1_unit)
   );

   lavm_normalize u_norm_up (
      .clock      (clock),
      .reset      (reset),
      .advance    (adv),
      .in_valid   (f_valid_ff),
      .in_vec     (f_up_ff),
      .out_valid  (n2_valid),
      .out_zero   (n2_zero),
      .out_scaled (n2_scaled),
      .out_unit   (n2_unit)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         eye_dly_ff[0] <= {f_eye_ff[2], f_eye_ff[1], f_eye_ff[0]};
         for (int j = 1; j < NORM_LATENCY; j++) begin
            eye_dly_ff[j] <= eye_dly_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_prod_ff[0] <= 64'(n1_scaled[1]) * 64'(n2_scaled[2]);
         x1_prod_ff[1] <= 64'(n1_scaled[2]) * 64'(n2_scaled[1]);
         x1_prod_ff[2] <= 64'(n1_scaled[2]) * 64'(n2_scaled[0]);
         x1_prod_ff[3] <= 64'(n1_scaled[0]) * 64'(n2_scaled[2]);
         x1_prod_ff[4] <= 64'(n1_scaled[0]) * 64'(n2_scaled[1]);
         x1_prod_ff[5] <= 64'(n1_scaled[1]) * 64'(n2_scaled[0]);
         x1_carry_ff.ok  <= !n1_zero && !n2_zero;
         x1_carry_ff.eye <= eye_dly_ff[NORM_LATENCY-1];
         for (int i = 0; i < 3; i++) begin
            x1_carry_ff.lu[i] <= n1_unit[i];
         end
         x2_cr_ff[0] <= x1_prod_ff[0] - x1_prod_ff[1];
         x2_cr_ff[1] <= x1_prod_ff[2] - x1_prod_ff[3];
         x2_cr_ff[2] <= x1_prod_ff[4] - x1_prod_ff[5];
         x2_carry_ff <= x1_carry_ff;
      end
   end

   lavm_normalize u_norm_right (
      .clock      (clock),
      .reset      (reset),
      .advance    (adv),
      .in_valid   (x2_valid_ff),
      .in_vec     (x2_cr_ff),
      .out_valid  (n3_valid),
      .out_zero   (n3_zero),
      .out_scaled (n3_scaled),
      .out_unit   (n3_unit)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         carry_dly_ff[0] <= x2_carry_ff;
         for (int j = 1; j < NORM_LATENCY; j++) begin
            carry_dly_ff[j] <= carry_dly_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      carry_type c;
      c = carry_dly_ff[NORM_LATENCY-1];
      if (adv) begin
         p1_prod_ff[0] <= 36'(n3_unit[1]) * 36'($signed(c.lu[2]));
         p1_prod_ff[1] <= 36'(n3_unit[2]) * 36'($signed(c.lu[1]));
         p1_prod_ff[2] <= 36'(n3_unit[2]) * 36'($signed(c.lu[0]));
         p1_prod_ff[3] <= 36'(n3_unit[0]) * 36'($signed(c.lu[2]));
         p1_prod_ff[4] <= 36'(n3_unit[0]) * 36'($signed(c.lu[1]));
         p1_prod_ff[5] <= 36'(n3_unit[1]) * 36'($signed(c.lu[0]));
         p1_ru_ff        <= n3_unit;
         p1_carry_ff.lu  <= c.lu;
         p1_carry_ff.eye <= c.eye;
         p1_carry_ff.ok  <= c.ok && !n3_zero;
      end
   end

   always_comb begin
      logic signed [35:0] pu;
      for (int i = 0; i < 3; i++) begin
         pu = round_q16(51'(p1_prod_ff[2*i]) - 51'(p1_prod_ff[2*i+1]));
         if (pu > 36'(Q_ONE)) begin
            p2_rows_in[1][i] = Q_ONE;
         end else if (pu < 36'(Q_MONE)) begin
            p2_rows_in[1][i] = Q_MONE;
         end else begin
            p2_rows_in[1][i] = pu[17:0];
         end
         p2_rows_in[0][i] = p1_ru_ff[i];
         p2_rows_in[2][i] = -$signed(p1_carry_ff.lu[i]);
      end
      if (!p1_carry_ff.ok) begin
         for (int r = 0; r < 3; r++) begin
            for (int i = 0; i < 3; i++) begin
               p2_rows_in[r][i] = (r == i) ? Q_ONE : 18'sd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_rows_ff <= p2_rows_in;
         p2_eye_ff  <= p1_carry_ff.eye;
         for (int r = 0; r < 3; r++) begin
            for (int i = 0; i < 3; i++) begin
               t1_prod_ff[r][i] <= 50'(p2_rows_ff[r][i]) * 50'($signed(p2_eye_ff[i]));
            end
         end
         t1_rows_ff <= p2_rows_ff;
      end
   end

   always_comb begin
      logic signed [36:0] nt;
      for (int r = 0; r < 3; r++) begin
         nt = -37'(round_q16(51'(t1_prod_ff[r][0]) + 51'(t1_prod_ff[r][1])
                           + 51'(t1_prod_ff[r][2])));
         if (nt > T_MAX) begin
            t_in[r] = T_MAX[31:0];
         end else if (nt < T_MIN) begin
            t_in[r] = T_MIN[31:0];
         end else begin
            t_in[r] = nt[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_rows_ff <= t1_rows_ff;
         rsp_t_ff    <= t_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_m00   = rsp_rows_ff[0][0];
   assign rsp_m01   = rsp_rows_ff[0][1];
   assign rsp_m02   = rsp_rows_ff[0][2];
   assign rsp_m10   = rsp_rows_ff[1][0];
   assign rsp_m11   = rsp_rows_ff[1][1];
   assign rsp_m12   = rsp_rows_ff[1][2];
   assign rsp_m20   = rsp_rows_ff[2][0];
   assign rsp_m21   = rsp_rows_ff[2][1];
   assign rsp_m22   = rsp_rows_ff[2][2];
   assign rsp_t0    = rsp_t_ff[0];
   assign rsp_t1    = rsp_t_ff[1];
   assign rsp_t2    = rsp_t_ff[2];

`ifndef SYNTHESIS
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> f_valid_ff)
      else $error("accepted transaction missing from first stage");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable({f_valid_ff, x1_valid_ff, x2_valid_ff, p1_valid_ff,
                        p2_valid_ff, t1_valid_ff}))
      else $error("pipeline moved during stall");

   a_up_row_range: assert property (@(posedge clock) disable iff (reset)
      p2_valid_ff |-> (p2_rows_ff[1][0] <= Q_ONE && p2_rows_ff[1][0] >= Q_MONE))
      else $error("corrected up out of range");

   a_norm_aligned: assert property (@(posedge clock) disable iff (reset)
      n1_valid == n2_valid)
      else $error("look and up normalize units out of step");
`endif

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import lavm_pkg::*;

   localparam int  PIPE_DEPTH  = 118;
   localparam int  CYCLE_LIMIT = 400000;
   localparam int  HOLD_CYCLES = 400;
   localparam int  N_PHASES    = 9;
   localparam int  PHASE_ITEMS = 150;

   typedef struct {
      logic signed [17:0] m [9];
      logic signed [31:0] t [3];
   } view_type;

   typedef struct packed {
      logic signed [31:0] ex, ey, ez, ax, ay, az;
      logic               ident;
      logic signed [31:0] t0, t1, t2;
   } dir_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_eye_x = '0, req_eye_y = '0, req_eye_z = '0;
   logic signed [31:0] req_aim_x = '0, req_aim_y = '0, req_aim_z = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [17:0] rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12;
   logic signed [17:0] rsp_m20, rsp_m21, rsp_m22;
   logic signed [31:0] rsp_t0, rsp_t1, rsp_t2;
   logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [3:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   logic signed [31:0] up_vec [3];
   view_type           view_q [$];
   view_type           typed_q [$];
   bit                 typed_flag_q [$];
   int                 errors = 0;
   int                 cycles = 0;
   bit                 idle_on = 1'b1;
   int                 hold_seq = 0;

   look_at_view_matrix_core dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic longint unsigned isqrt(input longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic bit normalize(input longint v [3], output longint s [3],
                                    output longint u [3]);
      longint unsigned m [3];
      longint unsigned mx, sum, len, q;
      bit ng [3];
      mx = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         ng[i] = v[i] < 0;
         m[i] = ng[i] ? longint'(-v[i]) : v[i];
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) return 1'b0;
      while (mx >= (64'd1 << 31)) begin
         mx >>= 1;
         for (int i = 0; i < 3; i++) m[i] >>= 1;
      end
      while (mx < (64'd1 << 30)) begin
         mx <<= 1;
         for (int i = 0; i < 3; i++) m[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) sum += m[i] * m[i];
      len = isqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << 16) + (len >> 1)) / len;
         s[i] = ng[i] ? -longint'(m[i]) : longint'(m[i]);
         u[i] = ng[i] ? -longint'(q) : longint'(q);
      end
      return 1'b1;
   endfunction

   function automatic longint round_q16(input longint v);
      longint unsigned m;
      m = ((v < 0 ? -v : v) + 64'h8000) >> 16;
      return v < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic view_type camera_view(input logic signed [31:0] eye_in [3],
                                            input logic signed [31:0] aim_in [3]);
      longint eye [3], look [3], up [3], ls [3], lu [3], us [3], uu [3];
      longint cr [3], rs [3], ru [3], pu [3], rows [3][3];
      longint acc;
      bit ok;
      view_type r;
      for (int i = 0; i < 3; i++) begin
         eye[i] = eye_in[i];
         look[i] = longint'(aim_in[i]) - eye[i];
         up[i] = up_vec[i];
      end
      ok = normalize(look, ls, lu);
      if (ok) ok = normalize(up, us, uu);
      if (ok) begin
         cr[0] = ls[1] * us[2] - ls[2] * us[1];
         cr[1] = ls[2] * us[0] - ls[0] * us[2];
         cr[2] = ls[0] * us[1] - ls[1] * us[0];
         ok = normalize(cr, rs, ru);
      end
      if (ok) begin
         pu[0] = round_q16(ru[1] * lu[2] - ru[2] * lu[1]);
         pu[1] = round_q16(ru[2] * lu[0] - ru[0] * lu[2]);
         pu[2] = round_q16(ru[0] * lu[1] - ru[1] * lu[0]);
         for (int i = 0; i < 3; i++) begin
            rows[0][i] = ru[i];
            rows[1][i] = clamp(pu[i], -65536, 65536);
            rows[2][i] = -lu[i];
         end
      end else begin
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               rows[i][j] = (i == j) ? 65536 : 0;
      end
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         for (int j = 0; j < 3; j++) begin
            r.m[i * 3 + j] = rows[i][j][17:0];
            acc += rows[i][j] * eye[j];
         end
         r.t[i] = 32'(clamp(-round_q16(acc), -64'sd2147483648, 64'sd2147483647));
      end
      return r;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d", what, got, want);
   endtask

   always @(posedge clock) begin
      logic signed [31:0] e [3], a [3];
      if (!reset && req_valid && req_ready) begin
         e = '{req_eye_x, req_eye_y, req_eye_z};
         a = '{req_aim_x, req_aim_y, req_aim_z};
         if (typed_flag_q.size() > 0 && typed_flag_q[0]) view_q.push_back(typed_q[0]);
         else view_q.push_back(camera_view(e, a));
         if (typed_flag_q.size() > 0) begin
            void'(typed_flag_q.pop_front());
            void'(typed_q.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      view_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.m = '{rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12,
                   rsp_m20, rsp_m21, rsp_m22};
         got.t = '{rsp_t0, rsp_t1, rsp_t2};
         if (view_q.size() == 0) begin
            report("unexpected transaction", 0, 0);
         end else begin
            want = view_q.pop_front();
            for (int i = 0; i < 9; i++)
               if (got.m[i] !== want.m[i])
                  report($sformatf("m%0d%0d", i / 3, i % 3), got.m[i], want.m[i]);
            for (int i = 0; i < 3; i++)
               if (got.t[i] !== want.t[i]) report($sformatf("t%0d", i), got.t[i], want.t[i]);
         end
      end
   end

   int stall_left = 0;
   int hold_left = 0;
   int hold_seen = 0;
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_valid && rsp_ready && idle_on) begin
         stall_left <= $urandom_range(0, 5);
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send(input logic signed [31:0] e [3], input logic signed [31:0] a [3],
                       input bit typed, input view_type tv);
      int gap;
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_eye_x, req_eye_y, req_eye_z} <= {e[0], e[1], e[2]};
      {req_aim_x, req_aim_y, req_aim_z} <= {a[0], a[1], a[2]};
      typed_flag_q.push_back(typed);
      typed_q.push_back(tv);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (view_q.size() > 0) @(posedge clock);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic signed [31:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      up_vec[idx] = val;
   endtask

   function automatic logic signed [31:0] rand_field(input int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 2097151)) - 1048576;
         2: return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
         default: return $signed($urandom_range(0, 262143)) - 131072;
      endcase
   endfunction

   task automatic random_item();
      logic signed [31:0] e [3], a [3];
      int mode, kind;
      view_type none;
      mode = $urandom_range(0, 3);
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
         e[i] = rand_field(mode);
         a[i] = rand_field($urandom_range(0, 3));
      end
      if (kind == 0) a = e;
      else if (kind == 1) for (int i = 0; i < 3; i++) a[i] = e[i] + (up_vec[i] >>> 4);
      else if (kind == 2) for (int i = 0; i < 3; i++) a[i] = e[i] - (up_vec[i] >>> 8);
      send(e, a, 1'b0, none);
   endtask

   initial begin
      dir_row_type dir_table [$];
      logic signed [31:0] e [3], a [3];
      logic signed [31:0] phase_up [N_PHASES][3];
      view_type tv;
      up_vec = '{32'sd0, 32'sd65536, 32'sd0};
      dir_table = '{
         '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1, 32'sd0, 32'sd0, 32'sd0},
         '{32'sd65536, 32'sd131072, 32'sd196608, 32'sd65536, 32'sd131072, 32'sd196608,
           1'b1, -32'sd65536, -32'sd131072, -32'sd196608},
         '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
           32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
           1'b1, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff},
         '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
           32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
           1'b1, -32'sh7fff_ffff, -32'sh7fff_ffff, -32'sh7fff_ffff},
         '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, -32'sd65536, 1'b1, 32'sd0, 32'sd0, 32'sd0},
         '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd327680, 32'sd0, 1'b1, 32'sd0, 32'sd0, 32'sd0},
         '{32'sd1, 32'sd2, 32'sd3, 32'sd1, -32'sd100, 32'sd3, 1'b1, -32'sd1, -32'sd2, -32'sd3},
         '{32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0, 1'b0, 32'sd0, 32'sd0, 32'sd0},
         '{32'sd10, 32'sd20, 32'sd30, -32'sd5, 32'sd7, 32'sd100000,
           1'b0, 32'sd0, 32'sd0, 32'sd0},
         '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd1,
           1'b0, 32'sd0, 32'sd0, 32'sd0},
         '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
           32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0, 32'sd0, 32'sd0, 32'sd0},
         '{32'sd5, 32'sd0, 32'sd0, 32'sd6, 32'sd0, 32'sd0, 1'b0, 32'sd0, 32'sd0, 32'sd0},
         '{32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd1, 1'b0, 32'sd0, 32'sd0, 32'sd0},
         '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sd0, 32'sd0, 32'sd0,
           1'b0, 32'sd0, 32'sd0, 32'sd0},
         '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sd0, 32'sd65536, 32'sd0,
           1'b0, 32'sd0, 32'sd0, 32'sd0},
         '{-32'sd1, 32'sd3, -32'sd7, 32'sd123456, -32'sd654321, 32'sd99,
           1'b0, 32'sd0, 32'sd0, 32'sd0}
      };
      phase_up = '{
         '{32'sd0, 32'sd65536, 32'sd0},
         '{32'sd0, 32'sd0, 32'sd65536},
         '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000},
         '{32'sd0, 32'sd0, 32'sd0},
         '{32'sd1, -32'sd1, 32'sd0},
         '{32'sd65536, 32'sd65536, 32'sd65536},
         '{32'sh7fff_ffff, 32'sd0, 32'sh7fff_ffff},
         '{$urandom, $urandom, $urandom},
         '{$signed($urandom_range(0, 131072)) - 65536, $signed($urandom_range(0, 131072)),
           $signed($urandom_range(0, 131072)) - 65536}
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_table[r]) begin
         e = '{dir_table[r].ex, dir_table[r].ey, dir_table[r].ez};
         a = '{dir_table[r].ax, dir_table[r].ay, dir_table[r].az};
         tv.m = '{Q_ONE, 18'sd0, 18'sd0, 18'sd0, Q_ONE, 18'sd0, 18'sd0, 18'sd0, Q_ONE};
         tv.t = '{dir_table[r].t0, dir_table[r].t1, dir_table[r].t2};
         send(e, a, dir_table[r].ident, tv);
      end
      drain();

      for (int p = 0; p < N_PHASES; p++) begin
         csr_write(REG_UP_X, phase_up[p][0]);
         csr_write(REG_UP_Y, phase_up[p][1]);
         csr_write(REG_UP_Z, phase_up[p][2]);
         idle_on = (p % 3) != 2;
         if (p == 2) hold_seq <= hold_seq + 1;
         for (int n = 0; n < PHASE_ITEMS; n++) random_item();
         drain();
      end

      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
